[rtl/nonpreemptive_priority_scheduler_macros.svh]
// Assertion macros for the nonpreemptive priority scheduler.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define NPS_ASSERT_SAME(label, clock, resetn, cond, conseq) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (conseq)) \
        else $error("scheduler check failed");

// Check that a condition implies a consequence in the next cycle.
`define NPS_ASSERT_NEXT(label, clock, resetn, cond, conseq) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (conseq)) \
        else $error("scheduler check failed");

`endif

[rtl/nps_pkg.sv]
// Shared constants and controller/datapath interface types for the scheduler.
package nps_pkg;

    localparam int MAX_PROCESSES = 64;
    localparam int IDX_W         = $clog2(MAX_PROCESSES);
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
    localparam int ARR_W         = 16;
    localparam int BUR_W         = 16;
    localparam int PRI_W         = 8;
    localparam int TIME_W        = 23;
    localparam int SUM_W         = 29;
    localparam int JOB_IDX_W     = 6;

    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
    } nps_entry_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic run_job;
        logic jump;
        logic calc_tat;
        logic calc_wt;
        logic emit;
    } nps_cmd_t;

    typedef struct packed {
        logic close_set;
        logic scan_busy;
        logic found;
        logic out_free;
        logic last_job;
    } nps_stat_t;

endpackage

[rtl/nps_ctrl.sv]
// Scheduler controller: sequences load, scan, decide, compute and emit steps.
module nps_ctrl
    import nps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  nps_stat_t stat,
    output nps_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_TAT,
        ST_WT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.close_set)
                    begin
                        state_next = ST_SCAN_START;
                    end
                end
            end
            ST_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.found)
                begin
                    cmd.run_job = 1'b1;
                    state_next  = ST_TAT;
                end
                else
                begin
                    cmd.jump   = 1'b1;
                    state_next = ST_SCAN_START;
                end
            end
            ST_TAT:
            begin
                cmd.calc_tat = 1'b1;
                state_next   = ST_WT;
            end
            ST_WT:
            begin
                cmd.calc_wt = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.last_job ? ST_LOAD : ST_SCAN_START;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/nps_datapath.sv]
// Scheduler datapath: job table, scan unit, time arithmetic and result register.
module nps_datapath
    import nps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nps_cmd_t             cmd,
    output nps_stat_t            stat,
    input  logic [ARR_W-1:0]     arrival_time,
    input  logic [BUR_W-1:0]     burst_time,
    input  logic [PRI_W-1:0]     job_priority,
    input  logic                 is_last_job,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [JOB_IDX_W-1:0] job_index,
    output logic [TIME_W-1:0]    completion_time,
    output logic [TIME_W-1:0]    turnaround_time,
    output logic [TIME_W-1:0]    waiting_time,
    output logic [SUM_W-1:0]     turnaround_sum,
    output logic [SUM_W-1:0]     waiting_sum,
    output logic                 is_last_result
);

    nps_entry_t job_mem [MAX_PROCESSES];
    nps_entry_t mem_q_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     emitted_reg;
    logic [MAX_PROCESSES-1:0] done_reg;
    logic [TIME_W-1:0]    clock_reg;
    logic [SUM_W-1:0]     tat_total_reg;
    logic [SUM_W-1:0]     wt_total_reg;

    logic                 issuing_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [PRI_W-1:0]     best_prio_reg;
    logic [ARR_W-1:0]     best_arr_reg;
    logic [BUR_W-1:0]     best_bur_reg;
    logic                 pend_found_reg;
    logic [ARR_W-1:0]     min_pend_reg;

    logic [TIME_W-1:0]    tat_reg;
    logic [TIME_W-1:0]    wt_reg;

    logic                 out_valid_reg;
    logic [JOB_IDX_W-1:0] job_index_reg;
    logic [TIME_W-1:0]    completion_reg;
    logic [TIME_W-1:0]    turnaround_reg;
    logic [TIME_W-1:0]    waiting_reg;
    logic [SUM_W-1:0]     tat_sum_reg;
    logic [SUM_W-1:0]     wt_sum_reg;
    logic                 last_result_reg;

    logic                 last_addr;
    logic                 entry_pending;
    logic                 entry_arrived;
    logic                 entry_better;
    logic                 entry_min;
    logic                 last_job;
    logic                 out_free;
    logic [SUM_W-1:0]     wt_total_next;

    assign last_addr     = ({1'b0, rd_addr_reg} + CNT_W'(1)) == count_reg;
    assign entry_pending = !done_reg[rd_idx_reg];
    assign entry_arrived = TIME_W'(mem_q_reg.arrival) <= clock_reg;
    assign entry_better  = !found_reg || (mem_q_reg.prio < best_prio_reg)
                           || ((mem_q_reg.prio == best_prio_reg)
                               && (mem_q_reg.arrival < best_arr_reg));
    assign entry_min     = !pend_found_reg || (mem_q_reg.arrival < min_pend_reg);
    assign last_job      = (emitted_reg + CNT_W'(1)) == count_reg;
    assign out_free      = !out_valid_reg || out_ready;
    assign wt_total_next = wt_total_reg + SUM_W'(wt_reg);

    always_comb
    begin
        stat.close_set = is_last_job || (count_reg == CNT_W'(MAX_PROCESSES - 1));
        stat.scan_busy = issuing_reg || rd_vld_reg;
        stat.found     = found_reg;
        stat.out_free  = out_free;
        stat.last_job  = last_job;
    end

    // job table
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            job_mem[count_reg[IDX_W-1:0]] <= '{arrival: arrival_time,
                                               burst:   burst_time,
                                               prio:    job_priority};
        end
        mem_q_reg <= job_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            emitted_reg    <= '0;
            done_reg       <= '0;
            clock_reg      <= '0;
            tat_total_reg  <= '0;
            wt_total_reg   <= '0;
            issuing_reg    <= 1'b0;
            rd_addr_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            pend_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // issue reads across the table
            rd_vld_reg <= issuing_reg;
            if (cmd.scan_start)
            begin
                issuing_reg    <= 1'b1;
                rd_addr_reg    <= '0;
                found_reg      <= 1'b0;
                pend_found_reg <= 1'b0;
            end
            else
            begin
                if (issuing_reg)
                begin
                    if (last_addr)
                    begin
                        issuing_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                    end
                end
                if (rd_vld_reg && entry_pending)
                begin
                    if (entry_arrived && entry_better)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (entry_min)
                    begin
                        pend_found_reg <= 1'b1;
                    end
                end
            end

            if (cmd.run_job)
            begin
                clock_reg <= clock_reg + TIME_W'(best_bur_reg);
            end
            else if (cmd.jump)
            begin
                clock_reg <= TIME_W'(min_pend_reg);
            end

            if (cmd.calc_wt)
            begin
                tat_total_reg <= tat_total_reg + SUM_W'(tat_reg);
            end

            if (cmd.emit)
            begin
                if (last_job)
                begin
                    count_reg     <= '0;
                    emitted_reg   <= '0;
                    done_reg      <= '0;
                    clock_reg     <= '0;
                    tat_total_reg <= '0;
                    wt_total_reg  <= '0;
                end
                else
                begin
                    emitted_reg            <= emitted_reg + CNT_W'(1);
                    done_reg[best_idx_reg] <= 1'b1;
                    wt_total_reg           <= wt_total_next;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.scan_start && rd_vld_reg && entry_pending)
        begin
            if (entry_arrived && entry_better)
            begin
                best_idx_reg  <= rd_idx_reg;
                best_prio_reg <= mem_q_reg.prio;
                best_arr_reg  <= mem_q_reg.arrival;
                best_bur_reg  <= mem_q_reg.burst;
            end
            if (entry_min)
            begin
                min_pend_reg <= mem_q_reg.arrival;
            end
        end
        rd_idx_reg <= rd_addr_reg;

        if (cmd.calc_tat)
        begin
            tat_reg <= clock_reg - TIME_W'(best_arr_reg);
        end
        if (cmd.calc_wt)
        begin
            wt_reg <= tat_reg - TIME_W'(best_bur_reg);
        end

        if (cmd.emit)
        begin
            job_index_reg   <= JOB_IDX_W'(best_idx_reg);
            completion_reg  <= clock_reg;
            turnaround_reg  <= tat_reg;
            waiting_reg     <= wt_reg;
            tat_sum_reg     <= last_job ? tat_total_reg : '0;
            wt_sum_reg      <= last_job ? wt_total_next : '0;
            last_result_reg <= last_job;
        end
    end

    assign out_valid       = out_valid_reg;
    assign job_index       = job_index_reg;
    assign completion_time = completion_reg;
    assign turnaround_time = turnaround_reg;
    assign waiting_time    = waiting_reg;
    assign turnaround_sum  = tat_sum_reg;
    assign waiting_sum     = wt_sum_reg;
    assign is_last_result  = last_result_reg;

endmodule

[rtl/nonpreemptive_priority_scheduler.sv]
// Top level of the nonpreemptive priority scheduler: controller plus datapath.
// Loading takes one cycle per job; the job that closes the set starts scheduling.
// Each decision scans the N stored jobs through the table read port, and scans
// again after the clock jumps to the next arrival when no stored job has arrived.
// rst_n clears control state, sums and clock at once; no clearing pass is needed.
`include "nonpreemptive_priority_scheduler_macros.svh"

module nonpreemptive_priority_scheduler
    import nps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ARR_W-1:0]     arrival_time,
    input  logic [BUR_W-1:0]     burst_time,
    input  logic [PRI_W-1:0]     job_priority,
    input  logic                 is_last_job,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [JOB_IDX_W-1:0] job_index,
    output logic [TIME_W-1:0]    completion_time,
    output logic [TIME_W-1:0]    turnaround_time,
    output logic [TIME_W-1:0]    waiting_time,
    output logic [SUM_W-1:0]     turnaround_sum,
    output logic [SUM_W-1:0]     waiting_sum,
    output logic                 is_last_result
);

    nps_cmd_t  cmd;
    nps_stat_t stat;

    nps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nps_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .job_priority    (job_priority),
        .is_last_job     (is_last_job),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .job_index       (job_index),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .turnaround_sum  (turnaround_sum),
        .waiting_sum     (waiting_sum),
        .is_last_result  (is_last_result)
    );

    `NPS_ASSERT_NEXT(a_close_stops_load, clk, rst_n,
                     in_valid && in_ready && is_last_job, !in_ready)
    `NPS_ASSERT_SAME(a_sums_zero, clk, rst_n, out_valid && !is_last_result,
                     (turnaround_sum == '0) && (waiting_sum == '0))
    `NPS_ASSERT_SAME(a_time_order, clk, rst_n, out_valid,
                     (waiting_time <= turnaround_time) && (turnaround_time <= completion_time))
    `NPS_ASSERT_SAME(a_sum_order, clk, rst_n, out_valid && is_last_result,
                     waiting_sum <= turnaround_sum)

endmodule
